// ----- rtl/ica_pkg.sv -----
// ----------------------------------------------------------------------------
// ica_pkg
// shared constants, types and helpers of the interval coverage accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package ica_pkg;

    localparam int MAP_POSITIONS = 65536;
    localparam int COUNT_BITS    = 32;
    localparam int POS_BITS      = 16;
    localparam int MULT_BITS     = 16;
    localparam int COV_BITS      = 32;
    localparam int FUNC_BITS     = 2;
    localparam int STATUS_BITS   = 2;

    localparam int ADDR_BITS = $clog2(MAP_POSITIONS);
    // wide enough for a 16-bit position and for the store depth itself
    localparam int CMP_BITS  = (ADDR_BITS + 1 > POS_BITS + 1) ? ADDR_BITS + 1 : POS_BITS + 1;
    localparam int SUM_BITS  = ((COUNT_BITS > MULT_BITS) ? COUNT_BITS : MULT_BITS) + 1;

    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [MULT_BITS-1:0]   mult_t;
    typedef logic [COV_BITS-1:0]    cov_t;
    typedef logic [FUNC_BITS-1:0]   func_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam func_t FUNC_CLEAR = 2'd0;
    localparam func_t FUNC_ADD   = 2'd1;
    localparam func_t FUNC_READ  = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_EMPTY   = 2'd1;
    localparam status_t STATUS_OUTSIDE = 2'd2;
    localparam status_t STATUS_BAD     = 2'd3;

    localparam addr_t               LAST_ADDR = addr_t'(MAP_POSITIONS - 1);
    localparam logic [CMP_BITS-1:0] POS_LIMIT = CMP_BITS'(MAP_POSITIONS);
    localparam count_t              COUNT_MAX = '1;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        count_t data;
    } ram_wr_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } ram_rd_t;

    typedef struct packed {
        cov_t    coverage;
        pos_t    low;
        pos_t    high;
        status_t status;
    } rsp_t;

    function automatic addr_t pos_to_addr(input pos_t pos);
        return addr_t'(pos);
    endfunction

    // saturating add of one multiplicity to a stored count
    function automatic count_t sat_add(input count_t cnt, input mult_t amt);
        logic [SUM_BITS-1:0] sum;
        logic [SUM_BITS-1:0] top;
        sum = SUM_BITS'(cnt) + SUM_BITS'(amt);
        top = SUM_BITS'(COUNT_MAX);
        return (sum > top) ? COUNT_MAX : count_t'(sum);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ica_store.sv -----
// ----------------------------------------------------------------------------
// ica_store
// coverage count memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ica_store (
    input  wire logic             aclk,
    input  wire ica_pkg::ram_wr_t wr,
    input  wire ica_pkg::ram_rd_t rd,
    output ica_pkg::count_t       rdata
);

    ica_pkg::count_t mem [0:ica_pkg::MAP_POSITIONS-1];
    ica_pkg::count_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/ica_ctrl.sv -----
// ----------------------------------------------------------------------------
// ica_ctrl
// command sequencer: clearing sweep, read-modify-write walk, bounds tracking
// ----------------------------------------------------------------------------
`default_nettype none

module ica_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ica_pkg::func_t    func,
    input  wire ica_pkg::pos_t     interval_start,
    input  wire ica_pkg::pos_t     interval_end,
    input  wire ica_pkg::mult_t    multiplicity,
    input  wire ica_pkg::pos_t     query_position,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ica_pkg::rsp_t          rsp,
    output ica_pkg::ram_wr_t       wr,
    output ica_pkg::ram_rd_t       rd,
    input  wire ica_pkg::count_t   rdata
);

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADD   = 5'b00100,
        S_READ  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    ica_pkg::addr_t    sweep_addr_reg, sweep_addr_next;
    logic              sweep_rsp_reg, sweep_rsp_next;
    ica_pkg::pos_t     low_reg, low_next;
    ica_pkg::pos_t     high_reg, high_next;
    logic              filled_reg, filled_next;
    logic              issue_reg, issue_next;
    logic              pend_reg, pend_next;
    ica_pkg::addr_t    cur_reg, cur_next;
    ica_pkg::addr_t    last_reg, last_next;
    ica_pkg::addr_t    wr_addr_reg, wr_addr_next;
    ica_pkg::mult_t    mult_reg, mult_next;
    logic              rd_ok_reg, rd_ok_next;
    ica_pkg::cov_t     cov_reg, cov_next;
    ica_pkg::status_t  status_reg, status_next;

    logic bad_interval;

    assign bad_interval = (interval_end < interval_start) ||
        (ica_pkg::CMP_BITS'(interval_end) >= ica_pkg::POS_LIMIT);

    assign in_ready         = (state_reg == S_IDLE);
    assign rsp_valid        = (state_reg == S_RESP);
    assign rsp.coverage     = cov_reg;
    assign rsp.low          = low_reg;
    assign rsp.high         = high_reg;
    assign rsp.status       = status_reg;

    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_rsp_next  = sweep_rsp_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        filled_next     = filled_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        wr_addr_next    = wr_addr_reg;
        mult_next       = mult_reg;
        rd_ok_next      = rd_ok_reg;
        cov_next        = cov_reg;
        status_next     = status_reg;
        wr              = '0;
        rd              = '0;

        unique case (state_reg)
            S_SWEEP: begin
                wr.en   = 1'b1;
                wr.addr = sweep_addr_reg;
                wr.data = '0;
                if (sweep_addr_reg == ica_pkg::LAST_ADDR) begin
                    sweep_addr_next = '0;
                    sweep_rsp_next  = 1'b0;
                    state_next      = sweep_rsp_reg ? S_RESP : S_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cov_next    = '0;
                    status_next = ica_pkg::STATUS_OK;
                    unique case (func)
                        ica_pkg::FUNC_CLEAR: begin
                            low_next       = '0;
                            high_next      = '0;
                            filled_next    = 1'b0;
                            sweep_rsp_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        ica_pkg::FUNC_ADD: begin
                            if (bad_interval) begin
                                status_next = ica_pkg::STATUS_BAD;
                                state_next  = S_RESP;
                            end else begin
                                // bounds as they stand after this add
                                if (!filled_reg) begin
                                    low_next  = interval_start;
                                    high_next = interval_end;
                                end else begin
                                    if (interval_start < low_reg) low_next = interval_start;
                                    if (interval_end > high_reg) high_next = interval_end;
                                end
                                filled_next = 1'b1;
                                cur_next    = ica_pkg::pos_to_addr(interval_start);
                                last_next   = ica_pkg::pos_to_addr(interval_end);
                                mult_next   = multiplicity;
                                issue_next  = 1'b1;
                                pend_next   = 1'b0;
                                state_next  = S_ADD;
                            end
                        end
                        ica_pkg::FUNC_READ: begin
                            rd.en   = 1'b1;
                            rd.addr = ica_pkg::pos_to_addr(query_position);
                            if (!filled_reg) begin
                                status_next = ica_pkg::STATUS_EMPTY;
                                rd_ok_next  = 1'b0;
                            end else if (query_position < low_reg ||
                                         query_position > high_reg) begin
                                status_next = ica_pkg::STATUS_OUTSIDE;
                                rd_ok_next  = 1'b0;
                            end else begin
                                rd_ok_next  = 1'b1;
                            end
                            state_next = S_READ;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // write back the count read last cycle
                if (pend_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = wr_addr_reg;
                    wr.data = ica_pkg::sat_add(rdata, mult_reg);
                end
                if (issue_reg) begin
                    rd.en        = 1'b1;
                    rd.addr      = cur_reg;
                    wr_addr_next = cur_reg;
                    pend_next    = 1'b1;
                    if (cur_reg == last_reg) begin
                        issue_next = 1'b0;
                    end else begin
                        cur_next = cur_reg + 1'b1;
                    end
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_READ: begin
                cov_next   = rd_ok_reg ? ica_pkg::COV_BITS'(rdata) : '0;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            sweep_addr_reg <= '0;
            sweep_rsp_reg  <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            filled_reg     <= 1'b0;
            issue_reg      <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_rsp_reg  <= sweep_rsp_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            filled_reg     <= filled_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        wr_addr_reg <= wr_addr_next;
        mult_reg    <= mult_next;
        rd_ok_reg   <= rd_ok_next;
        cov_reg     <= cov_next;
        status_reg  <= status_next;
    end

endmodule

`default_nettype wire

// ----- rtl/interval_coverage_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// interval_coverage_accumulator_unit
// add: one store read and one write-back per position of the interval, then the result beat
// read: one registered store read, then the result beat; clear: a sweep that zeroes every entry
// one command at a time, the walk over the store read port sets the rate
// reset (synchronous, aresetn low) empties the map and starts a clearing pass over
// every store entry; s_tready stays low until it ends
// ----------------------------------------------------------------------------
`default_nettype none

module interval_coverage_accumulator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input command beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // interval_start, interval_end, multiplicity, query_position
    input  wire logic [1:0]  s_tuser,   // func
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // coverage, map_low, map_high
    output logic [1:0]       m_tuser    // status
);

    ica_pkg::ram_wr_t wr;
    ica_pkg::ram_rd_t rd;
    ica_pkg::count_t  rdata;
    ica_pkg::rsp_t    rsp;
    logic             rsp_valid;
    logic             rsp_ready;

    // output register: holds one finished result while the sequencer goes on
    logic             m_valid_reg, m_valid_next;
    ica_pkg::rsp_t    m_data_reg, m_data_next;

    // sequencer: clearing sweep, read-modify-write walk over the store, bounds
    ica_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .func             (s_tuser),
        .interval_start   (s_tdata[15:0]),
        .interval_end     (s_tdata[31:16]),
        .multiplicity     (s_tdata[47:32]),
        .query_position   (s_tdata[63:48]),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .wr               (wr),
        .rd               (rd),
        .rdata            (rdata)
    );

    // coverage counts, one entry per position
    ica_store u_store (
        .aclk  (aclk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    // the slot frees up in the same cycle its beat is taken
    assign rsp_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.high, m_data_reg.low, m_data_reg.coverage};
    // status goes out on the side band
    assign m_tuser  = m_data_reg.status;

endmodule

`default_nettype wire

// ----- rtl/ica_checker.sv -----
// ----------------------------------------------------------------------------
// ica_checker
// port-level checks of the interval coverage accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module ica_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset drops the result and starts the clearing pass
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("block not quiet after reset");

    // any status but ok carries no coverage
    a_cov_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ica_pkg::STATUS_OK |-> m_tdata[31:0] == 32'd0)
        else $error("coverage on a failed command");

    // bounds stay ordered
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:32] <= m_tdata[63:48])
        else $error("map low above map high");

    // an empty map has zero bounds
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ica_pkg::STATUS_EMPTY |-> m_tdata[63:32] == 32'd0)
        else $error("empty map with nonzero bounds");

endmodule

bind interval_coverage_accumulator_unit ica_checker u_ica_checker (.*);

`default_nettype wire

// ----- sim/interval_coverage_accumulator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_coverage_accumulator_unit_tb
// self-checking bench for the interval coverage accumulator: clear, add, read and
// spare commands are driven in with random gaps, every result beat is checked
// against an in-bench depth map kept at full store size
// ----------------------------------------------------------------------------

module interval_coverage_accumulator_unit_tb;

    // spare selector code, not used by the block
    localparam ica_pkg::func_t FUNC_SPARE = 2'd3;

    // no-handshake cycles allowed, enough to cover a full clear or a full-range add
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int RANDOM_ITEMS   = 850;
    localparam int TAIL_CYCLES    = 100;
    localparam int HOLD_CYCLES    = 400;

    // one command beat
    typedef struct {
        ica_pkg::func_t func;
        ica_pkg::pos_t  span_first;
        ica_pkg::pos_t  span_last;
        ica_pkg::mult_t amount;
        ica_pkg::pos_t  query;
    } command_t;

    // one result beat
    typedef struct {
        ica_pkg::cov_t    coverage;
        ica_pkg::pos_t    low;
        ica_pkg::pos_t    high;
        ica_pkg::status_t status;
    } report_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // interval_start, interval_end, multiplicity, query_position
    logic [1:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // coverage, map_low, map_high
    logic [1:0]  m_tuser;         // status

    // expected depth map and bounds
    ica_pkg::count_t depth_at [ica_pkg::MAP_POSITIONS];
    ica_pkg::pos_t   bound_lo;
    ica_pkg::pos_t   bound_hi;
    bit              map_live;

    command_t waiting_cmds[$];    // commands not yet put on the bus
    command_t recent_adds[$];     // last few well-formed adds, for aiming reads
    report_t  due_reports[$];     // results still to come, oldest first
    command_t on_bus;

    // idling control
    bit calm = 1'b0;              // no gaps on either side while set
    int gap_left     = 0;
    int burst_left   = 0;
    int stall_left   = 0;
    int open_left    = 0;
    int hold_left    = 0;
    int beats_seen   = 0;
    int miss_count   = 0;
    int quiet_cycles = 0;

    interval_coverage_accumulator_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // depth map update for one accepted command, returns its result beat
    // ------------------------------------------------------------------
    function automatic report_t tally_command(input command_t c);
        report_t                      r;
        logic [ica_pkg::COUNT_BITS:0] sum;
        int                           p;
        r.coverage = '0;
        r.status   = ica_pkg::STATUS_OK;
        case (c.func)
            ica_pkg::FUNC_CLEAR: begin
                for (p = 0; p < ica_pkg::MAP_POSITIONS; p++) depth_at[p] = '0;
                bound_lo = '0;
                bound_hi = '0;
                map_live = 1'b0;
            end
            ica_pkg::FUNC_ADD: begin
                // reversed or out-of-store intervals leave everything as is
                if (c.span_last < c.span_first ||
                    int'(c.span_last) >= ica_pkg::MAP_POSITIONS) begin
                    r.status = ica_pkg::STATUS_BAD;
                end else begin
                    for (p = int'(c.span_first); p <= int'(c.span_last); p++) begin
                        sum = {1'b0, depth_at[p]} + (ica_pkg::COUNT_BITS + 1)'(c.amount);
                        // saturate at the top of the count width
                        depth_at[p] = sum[ica_pkg::COUNT_BITS] ? ica_pkg::COUNT_MAX :
                                      sum[ica_pkg::COUNT_BITS-1:0];
                    end
                    if (!map_live) begin
                        bound_lo = c.span_first;
                        bound_hi = c.span_last;
                        map_live = 1'b1;
                    end else begin
                        if (c.span_first < bound_lo) bound_lo = c.span_first;
                        if (c.span_last > bound_hi) bound_hi = c.span_last;
                    end
                end
            end
            ica_pkg::FUNC_READ: begin
                if (!map_live) begin
                    r.status = ica_pkg::STATUS_EMPTY;
                end else if (c.query < bound_lo || c.query > bound_hi) begin
                    r.status = ica_pkg::STATUS_OUTSIDE;
                end else begin
                    r.coverage = depth_at[c.query];
                end
            end
            default: ;  // spare selector: no change
        endcase
        r.low  = bound_lo;
        r.high = bound_hi;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input ica_pkg::func_t f, input int a, input int b, input int m,
                            input int q);
        command_t c;
        c.func       = f;
        c.span_first = ica_pkg::pos_t'(a);
        c.span_last  = ica_pkg::pos_t'(b);
        c.amount     = ica_pkg::mult_t'(m);
        c.query      = ica_pkg::pos_t'(q);
        waiting_cmds.insert(waiting_cmds.size(), c);
        if (f == ica_pkg::FUNC_ADD && b >= a) begin
            recent_adds.insert(recent_adds.size(), c);
            if (recent_adds.size() > 8) void'(recent_adds.pop_front());
        end
    endtask

    // multiplicity: often unit weight, with zero, the top value and random values mixed in
    function automatic int pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 1;
        if (r < 40) return 0;
        if (r < 50) return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    task automatic queue_random_add();
        int a;
        int b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // reversed interval, rejected by the block with a bad status
            a = $urandom_range(1, 16'hFFFF);
            b = $urandom_range(0, a - 1);
            push_cmd(ica_pkg::FUNC_ADD, a, b, pick_amount(), $urandom_range(0, 16'hFFFF));
        end else begin
            a = (r < 10) ? $urandom_range(0, 3) : $urandom_range(0, 16'hFFFF);
            r = $urandom_range(0, 99);
            // keep most spans short so that adds stay cheap
            if (r < 70)      b = a + $urandom_range(0, 63);
            else if (r < 95) b = a + $urandom_range(64, 511);
            else             b = a + $urandom_range(512, 4095);
            if (b > 16'hFFFF || $urandom_range(0, 19) == 0) b = 16'hFFFF;
            push_cmd(ica_pkg::FUNC_ADD, a, b, pick_amount(), $urandom_range(0, 16'hFFFF));
        end
    endtask

    task automatic queue_random_read();
        command_t k;
        int       lo_q;
        int       hi_q;
        if (recent_adds.size() == 0 || $urandom_range(0, 4) == 0) begin
            push_cmd(ica_pkg::FUNC_READ, $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF));
        end else begin
            // aim at a recent interval, a little past its edges
            k    = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
            lo_q = int'(k.span_first) - 2;
            hi_q = int'(k.span_last) + 2;
            if (lo_q < 0) lo_q = 0;
            if (hi_q > 16'hFFFF) hi_q = 16'hFFFF;
            push_cmd(ica_pkg::FUNC_READ, $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                     $urandom_range(lo_q, hi_q));
        end
    endtask

    // block until every queued command is taken and answered
    task automatic drain();
        while (waiting_cmds.size() != 0 || s_tvalid || due_reports.size() != 0)
            @(posedge aclk);
    endtask

    // gap before the next command beat
    function automatic int next_gap();
        int r;
        if (calm) return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // receiver readiness for the coming cycle
    function automatic bit next_ready();
        int r;
        if (calm) return 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            return 1'b0;
        end
        if (open_left > 0) begin
            open_left--;
            return 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            open_left = $urandom_range(20, 80);
            return 1'b1;
        end
        if (r < 70) return 1'b1;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // driver: pops pending commands, holds each beat until it is taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // an accepted command updates the expected map right away
            if (s_tvalid && s_tready)
                due_reports.insert(due_reports.size(), tally_command(on_bus));

            if (s_tvalid && !s_tready) begin
                // beat still waiting for the block, leave it on the bus
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (waiting_cmds.size() != 0) begin
                on_bus = waiting_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {on_bus.query, on_bus.amount, on_bus.span_last, on_bus.span_first};
                s_tuser  <= on_bus.func;
                gap_left = next_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result beat, drives m_tready with random stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.coverage = m_tdata[31:0];
                got.low      = m_tdata[47:32];
                got.high     = m_tdata[63:48];
                got.status   = m_tuser;
                beats_seen++;
                if (due_reports.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("result beat %0d arrived with nothing expected", beats_seen);
                end else begin
                    want = due_reports.pop_front();
                    if (got.coverage != want.coverage || got.low != want.low ||
                        got.high != want.high || got.status != want.status) begin
                        miss_count++;
                        if (miss_count <= 10)
                            $display({"beat %0d exp cov %h lo %h hi %h st %0d,",
                                      " got cov %h lo %h hi %h st %0d"},
                                     beats_seen, want.coverage, want.low, want.high,
                                     want.status, got.coverage, got.low, got.high,
                                     got.status);
                    end
                end
                // long hold-off so that the block backs up and stalls its input
                if (beats_seen == 150 || beats_seen == 600) hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= next_ready();
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no beat on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int i;
        int r;

        // reset state of the expected map
        for (i = 0; i < ica_pkg::MAP_POSITIONS; i++) depth_at[i] = '0;
        bound_lo = '0;
        bound_hi = '0;
        map_live = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: bounds edges, every command, empty and outside reads
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 0);                  // empty map after reset
        push_cmd(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(ica_pkg::FUNC_ADD, 16'hFFFF, 0, 16'hFFFF, 0);     // reversed interval
        push_cmd(ica_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0); // first add sets bounds
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'hFFFF);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 0);                  // below the map
        push_cmd(ica_pkg::FUNC_ADD, 0, 0, 0, 0);                   // zero weight still widens
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 0);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h8000);
        push_cmd(ica_pkg::FUNC_ADD, 16'h1234, 16'h1240, 1, 0);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h1234);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h1240);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h1241);
        push_cmd(FUNC_SPARE, 0, 0, 0, 0);
        push_cmd(ica_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 5);                  // empty after clear
        push_cmd(ica_pkg::FUNC_ADD, 100, 200, 7, 0);               // first add after clear
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 99);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 201);                // above the map
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 150);
        push_cmd(ica_pkg::FUNC_ADD, 50, 60, 16'hFFFF, 0);          // widens low bound
        push_cmd(ica_pkg::FUNC_ADD, 300, 310, 3, 0);               // widens high bound
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 55);
        push_cmd(ica_pkg::FUNC_ADD, 16'hAAAA, 16'h5555, 2, 0);     // reversed again
        drain();

        // random part: adds and reads with random content, rare clears
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 250 == 249) begin
                push_cmd(ica_pkg::FUNC_CLEAR, $urandom_range(0, 16'hFFFF),
                         $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                         $urandom_range(0, 16'hFFFF));
                recent_adds.delete();
            end else if (i == 400) begin
                // one add over the whole store
                push_cmd(ica_pkg::FUNC_ADD, 0, 16'hFFFF, pick_amount(), 0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 48)      queue_random_add();
                else if (r < 97) queue_random_read();
                else push_cmd(FUNC_SPARE, $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF));
            end
        end
        drain();

        // back to back tail: overlapping adds around one position
        calm = 1'b1;
        push_cmd(ica_pkg::FUNC_ADD, 16'h4000, 16'h4000, 16'hFFFF, 0);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h4000);
        push_cmd(ica_pkg::FUNC_ADD, 16'h3FFF, 16'h4001, 5, 0);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h4000);
        push_cmd(ica_pkg::FUNC_READ, 0, 0, 0, 16'h3FFF);
        drain();
        calm = 1'b0;

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        miss_count += due_reports.size();
        if (miss_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ica_pkg.sv
rtl/ica_store.sv
rtl/ica_ctrl.sv
rtl/interval_coverage_accumulator_unit.sv
rtl/ica_checker.sv
sim/interval_coverage_accumulator_unit_tb.sv
